// File: design/can_fast_packet_reassembler_core_defines.svh
// Assertion macros for the fast-packet reassembler.
// Included by the reassembler core, which carries the concurrent assertions; no dependencies.
`ifndef CAN_FAST_PACKET_REASSEMBLER_CORE_DEFINES_SVH
`define CAN_FAST_PACKET_REASSEMBLER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFPR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CFPR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: design/cfpr_pkg.sv
// Types, constants and the fast-packet group lookup for the reassembler.
// No dependencies.
package cfpr_pkg;

  localparam int unsigned PgnCount = 36;
  localparam logic [7:0] MaxLen = 8'd223;
  localparam logic [8:0] PayloadBytes = 9'd224;

  typedef enum logic [2:0] {
    ST_PASS     = 3'd0,
    ST_PROGRESS = 3'd1,
    ST_CHUNK    = 3'd2,
    ST_DROP     = 3'd3,
    ST_ORPHAN   = 3'd4,
    ST_FULL     = 3'd5,
    ST_TICK     = 3'd6
  } result_status_e;

  typedef enum logic [0:0] {
    OP_FRAME = 1'b0,
    OP_TICK  = 1'b1
  } operation_e;

  typedef enum logic [0:0] {
    REG_ENTRY_MAX_AGE = 1'b0,
    REG_GC_INTERVAL   = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic        operation;
    logic [28:0] can_id;
    logic [63:0] frame_data;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [16:0] pgn;
    logic [7:0]  source;
    logic [7:0]  destination;
    logic [2:0]  priority_res;
    logic [7:0]  length;
    logic [63:0] payload_chunk;
    logic        last;
    logic [15:0] dropped_count;
  } out_item_t;

  localparam logic [16:0] FastPgns [PgnCount] = '{
    17'd65240,  17'd126208, 17'd126464, 17'd126996, 17'd126998, 17'd127233,
    17'd127237, 17'd127489, 17'd127496, 17'd127506, 17'd128275, 17'd129029,
    17'd129038, 17'd129039, 17'd129040, 17'd129041, 17'd129284, 17'd129285,
    17'd129540, 17'd129793, 17'd129794, 17'd129795, 17'd129797, 17'd129798,
    17'd129801, 17'd129802, 17'd129808, 17'd129809, 17'd129810, 17'd130065,
    17'd130074, 17'd130323, 17'd130577, 17'd130820, 17'd130822, 17'd130824
  };

  // True when the group is one of the fixed fast-packet groups.
  function automatic logic is_fast_pgn(logic [16:0] pgn);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < PgnCount; i++) begin
      if (FastPgns[i] == pgn) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

// File: design/cfpr_in_if.sv
// Input channel of the reassembler: valid/ready transfer of one input item.
// Depends on cfpr_pkg.
interface cfpr_in_if import cfpr_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: design/cfpr_out_if.sv
// Output channel of the reassembler: valid/ready transfer of one result item.
// Depends on cfpr_pkg.
interface cfpr_out_if import cfpr_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: design/can_fast_packet_reassembler_core.sv
// Channel   Dir  Contents
// in_i      in   operation, can_id, frame_data
// out_o     out  status, pgn, source, destination, priority_res, length,
//                payload_chunk, last, dropped_count
// A passthrough frame goes from decode to output, and a tick walks every slot and then
// outputs. A fast frame passes decode, slot search and action, then 6 or 7 payload
// byte writes when it opens or extends a message, then output; a finished message is
// output as 8-byte chunks, each read byte by byte through the payload memory's read
// port before it is output.
// Reset clears slot valid bits and both counters at once; no clearing pass.
// A result waits in the output register until transferred; no new item is
// taken until every result of the current one has been transferred.
// Depends on cfpr_pkg, cfpr_in_if, cfpr_out_if and the defines header.
`include "can_fast_packet_reassembler_core_defines.svh"

module can_fast_packet_reassembler_core import cfpr_pkg::*; #(
  parameter int unsigned SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cfpr_in_if.sink     in_i,
  cfpr_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned SD = 1 << IW;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned MemDepth = SD * 256;
  localparam logic [CW-1:0] LastSlot = CW'(SLOTS - 1);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DECODE = 9'b000000010,
    S_SEARCH = 9'b000000100,
    S_ACT    = 9'b000001000,
    S_WRITE  = 9'b000010000,
    S_RD     = 9'b000100000,
    S_CAP    = 9'b001000000,
    S_OUT    = 9'b010000000,
    S_TICK   = 9'b100000000
  } fsm_e;

  fsm_e state_q, state_d;

  // Configuration registers.
  logic [15:0] max_age_q, gc_int_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_age_q <= 16'd100;
      gc_int_q  <= 16'd10;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ENTRY_MAX_AGE: max_age_q <= cfg_data_i;
        REG_GC_INTERVAL:   gc_int_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Slot table.
  logic        valid_q [SD];
  logic [7:0]  seq_q   [SD];
  logic [16:0] pgn_q   [SD];
  logic [7:0]  src_q   [SD];
  logic [7:0]  dst_q   [SD];
  logic [2:0]  pri_q   [SD];
  logic [7:0]  len_q   [SD];
  logic [7:0]  cur_q   [SD];
  logic [15:0] age_q   [SD];

  // Captured item and sequencer registers.
  logic [28:0]   id_q;
  logic [63:0]   data_q;
  logic [CW-1:0] scnt_q;
  logic          hit_ok_q, free_ok_q;
  logic [IW-1:0] hit_q, free_q, es_q;
  logic [7:0]    wbase_q;
  logic [2:0]    woff_q, wcnt_q, wlast_q;
  logic          wdone_q;
  logic [4:0]    chunk_q;
  logic [2:0]    byte_q;
  logic [63:0]   acc_q;
  logic          emit_q, sweep_q;
  logic [15:0]   sweep_cnt_q, drop_q;
  logic [7:0]    expired_q;
  out_item_t     res_q;

  // Identifier decode.
  logic [7:0]  f_src, f_b1, f_b2;
  logic [4:0]  f_b3;
  logic [7:0]  f_dst, f_seq;
  logic [16:0] f_pgn;
  logic [2:0]  f_pri;
  logic [7:0]  f_len;

  assign f_src = id_q[7:0];
  assign f_b1  = id_q[15:8];
  assign f_b2  = id_q[23:16];
  assign f_b3  = id_q[28:24];
  assign f_dst = (f_b2 < 8'd240) ? f_b1 : 8'hFF;
  assign f_pgn = {f_b3[0], f_b2, (f_b2 < 8'd240) ? 8'h00 : f_b1};
  assign f_pri = f_b3[4:2];
  assign f_seq = data_q[7:0];
  assign f_len = (data_q[15:8] > MaxLen) ? MaxLen : data_q[15:8];

  // Shared slot compare, one slot per cycle.
  logic [IW-1:0] sidx;
  logic          s_match;
  assign sidx    = scnt_q[IW-1:0];
  assign s_match = valid_q[sidx] && (seq_q[sidx][7:5] == f_seq[7:5]) &&
                   (pgn_q[sidx] == f_pgn) && (src_q[sidx] == f_src) &&
                   (dst_q[sidx] == f_dst);

  // Payload memory, byte wide, with one write port and one read port.
  logic [7:0]      mem [MemDepth];
  logic [8:0]      widx;
  logic            wr_en;
  logic [7:0]      wbyte;
  logic [7:0]      ridx;
  logic [7:0]      rdata_q;
  logic [IW+7:0]   raddr;

  assign widx  = {1'b0, wbase_q} + {6'd0, wcnt_q};
  assign wr_en = (state_q == S_WRITE) && (widx < PayloadBytes);
  assign wbyte = data_q[{woff_q + wcnt_q, 3'b000} +: 8];
  assign ridx  = {chunk_q, byte_q};
  assign raddr = {es_q, ridx};

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[{es_q, widx[7:0]}] <= wbyte;
    rdata_q <= mem[raddr];
  end

  // Derived values for the action step and the emitter.
  logic [IW-1:0]  tgt;
  logic [8:0]     cur_sum;
  logic [7:0]     cur_new;
  logic [8:0]     next_idx;
  logic           chunk_last;
  logic [15:0]    age_inc;
  logic [15:0]    sweep_inc;
  logic [7:0]     cap_byte;
  logic           tick_exp;
  result_status_e act_status;

  assign tgt        = hit_ok_q ? hit_q : free_q;
  assign cur_sum    = {1'b0, cur_q[hit_q]} + 9'd7;
  assign cur_new    = cur_sum[8] ? 8'hFF : cur_sum[7:0];
  assign next_idx   = {1'b0, chunk_q, 3'b000} + 9'd8;
  assign chunk_last = next_idx >= {1'b0, len_q[es_q]};
  assign age_inc    = (age_q[sidx] == 16'hFFFF) ? age_q[sidx] : age_q[sidx] + 16'd1;
  assign sweep_inc  = (sweep_cnt_q == 16'hFFFF) ? sweep_cnt_q : sweep_cnt_q + 16'd1;
  // Bytes at or past the message length read as zero.
  assign cap_byte   = ({1'b0, ridx} < {1'b0, len_q[es_q]}) ? rdata_q : 8'h00;
  assign tick_exp   = valid_q[sidx] && sweep_q && (age_inc > max_age_q);

  // Status of an item whose result is decided at the action step.
  always_comb begin
    act_status = ST_FULL;
    if (hit_ok_q && (9'(seq_q[hit_q]) + 9'd1 != 9'(f_seq)) && (f_seq[4:0] != 5'd0)) begin
      act_status = ST_DROP;
    end else if (!hit_ok_q && (f_seq[4:0] != 5'd0)) begin
      act_status = ST_ORPHAN;
    end
  end

  assign in_i.ready    = (state_q == S_IDLE);
  assign out_o.valid   = (state_q == S_OUT);
  assign out_o.payload = res_q;

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          state_d = (in_i.payload.operation == OP_TICK) ? S_TICK : S_DECODE;
        end
      end
      S_DECODE: state_d = is_fast_pgn(f_pgn) ? S_SEARCH : S_OUT;
      S_SEARCH: if (scnt_q == LastSlot) state_d = S_ACT;
      S_ACT: begin
        if (hit_ok_q) begin
          state_d = ((9'(seq_q[hit_q]) + 9'd1 == 9'(f_seq)) || (f_seq[4:0] == 5'd0)) ?
                    S_WRITE : S_OUT;
        end else begin
          state_d = (f_seq[4:0] == 5'd0 && free_ok_q) ? S_WRITE : S_OUT;
        end
      end
      S_WRITE:  if (wcnt_q == wlast_q) state_d = wdone_q ? S_RD : S_OUT;
      S_RD:     state_d = S_CAP;
      S_CAP:    state_d = (byte_q == 3'd7) ? S_OUT : S_RD;
      S_OUT: begin
        if (out_o.ready) state_d = res_q.last ? S_IDLE : S_RD;
      end
      S_TICK:   if (scnt_q == LastSlot) state_d = S_OUT;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  // Control registers: slot valid bits, counters and flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SD; i++) valid_q[i] <= 1'b0;
      sweep_cnt_q <= '0;
      drop_q      <= '0;
      scnt_q      <= '0;
      hit_ok_q    <= 1'b0;
      free_ok_q   <= 1'b0;
      emit_q      <= 1'b0;
      sweep_q     <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          scnt_q    <= '0;
          hit_ok_q  <= 1'b0;
          free_ok_q <= 1'b0;
          emit_q    <= 1'b0;
          if (in_i.valid && in_i.payload.operation == OP_TICK) begin
            sweep_q     <= (sweep_inc >= gc_int_q);
            sweep_cnt_q <= (sweep_inc >= gc_int_q) ? 16'd0 : sweep_inc;
          end
        end
        S_SEARCH: begin
          scnt_q <= scnt_q + CW'(1);
          if (s_match && !hit_ok_q) hit_ok_q <= 1'b1;
          if (!valid_q[sidx] && !free_ok_q) free_ok_q <= 1'b1;
        end
        S_ACT: begin
          if (hit_ok_q && (9'(seq_q[hit_q]) + 9'd1 != 9'(f_seq)) &&
              (f_seq[4:0] != 5'd0)) begin
            valid_q[hit_q] <= 1'b0;
            if (drop_q != 16'hFFFF) drop_q <= drop_q + 16'd1;
          end else if (hit_ok_q || (f_seq[4:0] == 5'd0 && free_ok_q)) begin
            valid_q[tgt] <= 1'b1;
          end
        end
        S_WRITE:  if (wcnt_q == wlast_q) emit_q <= wdone_q;
        S_OUT: begin
          if (out_o.ready && res_q.last && emit_q) valid_q[es_q] <= 1'b0;
        end
        S_TICK: begin
          scnt_q <= scnt_q + CW'(1);
          if (sweep_q && valid_q[sidx] && age_inc > max_age_q) valid_q[sidx] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Payload-side registers: captured item, slot fields, writer and emitter.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        id_q      <= in_i.payload.can_id;
        data_q    <= in_i.payload.frame_data;
        expired_q <= '0;
      end
      S_DECODE: begin
        res_q <= '{status: ST_PASS, pgn: f_pgn, source: f_src, destination: f_dst,
                   priority_res: f_pri, length: 8'd8, payload_chunk: data_q,
                   last: 1'b1, dropped_count: drop_q};
      end
      S_SEARCH: begin
        if (s_match && !hit_ok_q) hit_q <= sidx;
        if (!valid_q[sidx] && !free_ok_q) free_q <= sidx;
      end
      S_ACT: begin
        res_q <= '{status: act_status, pgn: f_pgn, source: f_src, destination: f_dst,
                   priority_res: f_pri, length: 8'd0, payload_chunk: 64'd0, last: 1'b1,
                   dropped_count: (act_status == ST_DROP && drop_q != 16'hFFFF) ?
                                  drop_q + 16'd1 : drop_q};
        wcnt_q  <= '0;
        chunk_q <= '0;
        byte_q  <= '0;
        acc_q   <= '0;
        es_q    <= tgt;
        if (hit_ok_q && (9'(seq_q[hit_q]) + 9'd1 == 9'(f_seq))) begin
          // In sequence: append seven bytes at the cursor.
          wbase_q        <= cur_q[hit_q];
          woff_q         <= 3'd1;
          wlast_q        <= 3'd6;
          wdone_q        <= (cur_new >= len_q[hit_q]);
          seq_q[hit_q]   <= f_seq;
          cur_q[hit_q]   <= cur_new;
        end else if (f_seq[4:0] == 5'd0 && (hit_ok_q || free_ok_q)) begin
          // Start frame: open, or reopen the matching slot.
          wbase_q    <= 8'd0;
          woff_q     <= 3'd2;
          wlast_q    <= 3'd5;
          wdone_q    <= (f_len <= 8'd6);
          seq_q[tgt] <= f_seq;
          pgn_q[tgt] <= f_pgn;
          src_q[tgt] <= f_src;
          dst_q[tgt] <= f_dst;
          pri_q[tgt] <= f_pri;
          len_q[tgt] <= f_len;
          cur_q[tgt] <= 8'd6;
          age_q[tgt] <= 16'd0;
        end
      end
      S_WRITE: begin
        wcnt_q <= wcnt_q + 3'd1;
        res_q  <= '{status: ST_PROGRESS, pgn: f_pgn, source: f_src, destination: f_dst,
                    priority_res: f_pri, length: len_q[es_q], payload_chunk: 64'd0,
                    last: 1'b1, dropped_count: drop_q};
      end
      S_CAP: begin
        acc_q[{byte_q, 3'b000} +: 8] <= cap_byte;
        byte_q <= byte_q + 3'd1;
        if (byte_q == 3'd7) begin
          res_q <= '{status: ST_CHUNK, pgn: pgn_q[es_q], source: src_q[es_q],
                     destination: dst_q[es_q], priority_res: pri_q[es_q],
                     length: len_q[es_q], payload_chunk: {cap_byte, acc_q[55:0]},
                     last: chunk_last, dropped_count: drop_q};
        end
      end
      S_OUT: begin
        if (out_o.ready && !res_q.last) begin
          chunk_q <= chunk_q + 5'd1;
          byte_q  <= '0;
          acc_q   <= '0;
        end
      end
      S_TICK: begin
        if (valid_q[sidx]) age_q[sidx] <= age_inc;
        if (tick_exp) expired_q <= expired_q + 8'd1;
        res_q <= '{status: ST_TICK, pgn: 17'd0, source: 8'd0, destination: 8'd0,
                   priority_res: 3'd0,
                   length: tick_exp ? expired_q + 8'd1 : expired_q,
                   payload_chunk: 64'd0, last: 1'b1, dropped_count: drop_q};
      end
      default: ;
    endcase
  end

  // Checks on the sequencer and counters.
  `CFPR_ASSERT_IMP(a_ready_excl, clk_i, rst_ni, in_i.ready, !out_o.valid)
  `CFPR_ASSERT_NXT(a_busy_after, clk_i, rst_ni, in_i.valid && in_i.ready, !in_i.ready)
  `CFPR_ASSERT_IMP(a_wr_range, clk_i, rst_ni, wr_en, widx < PayloadBytes)
  `CFPR_ASSERT_NXT(a_drop_mono, clk_i, rst_ni, 1'b1, drop_q >= $past(drop_q))

endmodule

// File: bench/tb_can_fast_packet_reassembler_core.sv
// Self-checking bench for the fast-packet reassembler core.
// Predicts every result from an internal model of the slot table and checks each transfer.
// Depends on cfpr_pkg, cfpr_in_if, cfpr_out_if and can_fast_packet_reassembler_core.
`timescale 1ns / 1ps

module tb_can_fast_packet_reassembler_core;
  import cfpr_pkg::*;

  localparam int unsigned NumSlots = 8;
  localparam int unsigned StoreBytes = 224;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  cfg_reg_e cfg_idx_i = REG_ENTRY_MAX_AGE;
  logic [15:0] cfg_data_i = '0;

  cfpr_in_if in_ch ();
  cfpr_out_if out_ch ();

  can_fast_packet_reassembler_core #(.SLOTS(NumSlots)) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_ch.sink),
    .out_o     (out_ch.source),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // Clock generation.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state.
  logic [15:0] age_limit;
  logic [15:0] sweep_every;
  logic        open_q [NumSlots];
  logic [7:0]  seq_q [NumSlots];
  logic [16:0] pgn_q [NumSlots];
  logic [7:0]  src_q [NumSlots];
  logic [7:0]  dst_q [NumSlots];
  logic [2:0]  pri_q [NumSlots];
  logic [7:0]  len_q [NumSlots];
  logic [7:0]  cur_q [NumSlots];
  logic [15:0] age_q [NumSlots];
  logic [7:0]  msg_bytes [NumSlots][StoreBytes];
  logic [15:0] sweep_cnt;
  logic [15:0] drop_cnt;

  out_item_t expected_results [$];
  int  fail_count = 0;
  int  items_sent = 0;
  bit  quiet_run = 1'b0;

  function automatic bit fast_group(logic [16:0] pgn);
    case (pgn)
      17'd65240, 17'd126208, 17'd126464, 17'd126996, 17'd126998, 17'd127233,
      17'd127237, 17'd127489, 17'd127496, 17'd127506, 17'd128275, 17'd129029,
      17'd129038, 17'd129039, 17'd129040, 17'd129041, 17'd129284, 17'd129285,
      17'd129540, 17'd129793, 17'd129794, 17'd129795, 17'd129797, 17'd129798,
      17'd129801, 17'd129802, 17'd129808, 17'd129809, 17'd129810, 17'd130065,
      17'd130074, 17'd130323, 17'd130577, 17'd130820, 17'd130822,
      17'd130824: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic push_result(result_status_e st, logic [16:0] pgn, logic [7:0] src,
                             logic [7:0] dst, logic [2:0] pri, logic [7:0] len,
                             logic [63:0] pay, logic lst);
    out_item_t r;
    r.status = st;
    r.pgn = pgn;
    r.source = src;
    r.destination = dst;
    r.priority_res = pri;
    r.length = len;
    r.payload_chunk = pay;
    r.last = lst;
    r.dropped_count = drop_cnt;
    expected_results = {expected_results, r};
  endtask

  // Stream a finished message as chunks and release its slot.
  task automatic stream_message(int s);
    int n;
    logic [63:0] chunk;
    n = (len_q[s] == 0) ? 1 : (int'(len_q[s]) + 7) / 8;
    for (int c = 0; c < n; c++) begin
      chunk = '0;
      for (int b = 0; b < 8; b++) begin
        if (c * 8 + b < len_q[s]) chunk[8*b +: 8] = msg_bytes[s][c*8+b];
      end
      push_result(ST_CHUNK, pgn_q[s], src_q[s], dst_q[s], pri_q[s], len_q[s], chunk,
                  c == n - 1);
    end
    open_q[s] = 1'b0;
  endtask

  task automatic start_message(int s, logic [16:0] pgn, logic [7:0] src, logic [7:0] dst,
                               logic [2:0] pri, logic [63:0] d);
    logic [7:0] len;
    len = (d[15:8] > MaxLen) ? MaxLen : d[15:8];
    open_q[s] = 1'b1;
    seq_q[s] = d[7:0];
    pgn_q[s] = pgn;
    src_q[s] = src;
    dst_q[s] = dst;
    pri_q[s] = pri;
    len_q[s] = len;
    cur_q[s] = 8'd6;
    age_q[s] = '0;
    for (int i = 0; i < 6; i++) msg_bytes[s][i] = d[8*(i+2) +: 8];
    if (len <= 6) stream_message(s);
    else push_result(ST_PROGRESS, pgn, src, dst, pri, len, '0, 1'b1);
  endtask

  // Work out the expected results of one accepted input item.
  task automatic predict_item(in_item_t it);
    logic [7:0] src, b1, b2, dst, seq;
    logic [4:0] b3;
    logic [16:0] pgn;
    logic [2:0] pri;
    int hit, cur, nfree;
    logic [7:0] expired;
    if (it.operation == OP_TICK) begin
      expired = '0;
      for (int s = 0; s < NumSlots; s++)
        if (open_q[s] && age_q[s] != 16'hFFFF) age_q[s]++;
      if (sweep_cnt != 16'hFFFF) sweep_cnt++;
      if (sweep_cnt >= sweep_every) begin
        sweep_cnt = '0;
        for (int s = 0; s < NumSlots; s++)
          if (open_q[s] && age_q[s] > age_limit) begin
            open_q[s] = 1'b0;
            expired++;
          end
      end
      push_result(ST_TICK, '0, '0, '0, '0, expired, '0, 1'b1);
      return;
    end
    src = it.can_id[7:0];
    b1 = it.can_id[15:8];
    b2 = it.can_id[23:16];
    b3 = it.can_id[28:24];
    dst = (b2 < 8'd240) ? b1 : 8'd255;
    pgn = {b3[0], b2, (b2 < 8'd240) ? 8'd0 : b1};
    pri = b3[4:2];
    if (!fast_group(pgn)) begin
      push_result(ST_PASS, pgn, src, dst, pri, 8'd8, it.frame_data, 1'b1);
      return;
    end
    seq = it.frame_data[7:0];
    hit = -1;
    for (int s = 0; s < NumSlots; s++)
      if (hit < 0 && open_q[s] && seq[7:5] == seq_q[s][7:5] && pgn_q[s] == pgn &&
          src_q[s] == src && dst_q[s] == dst) hit = s;
    if (hit < 0) begin
      if (seq[4:0] != 0) begin
        push_result(ST_ORPHAN, pgn, src, dst, pri, '0, '0, 1'b1);
        return;
      end
      nfree = -1;
      for (int s = NumSlots - 1; s >= 0; s--) if (!open_q[s]) nfree = s;
      if (nfree >= 0) start_message(nfree, pgn, src, dst, pri, it.frame_data);
      else push_result(ST_FULL, pgn, src, dst, pri, '0, '0, 1'b1);
      return;
    end
    if (int'(seq_q[hit]) + 1 == int'(seq)) begin
      cur = cur_q[hit];
      for (int i = 0; i < 7; i++)
        if (cur + i < StoreBytes) msg_bytes[hit][cur+i] = it.frame_data[8*(i+1) +: 8];
      seq_q[hit] = seq;
      cur += 7;
      if (cur > 255) cur = 255;
      cur_q[hit] = cur[7:0];
      if (cur >= len_q[hit]) stream_message(hit);
      else push_result(ST_PROGRESS, pgn, src, dst, pri, len_q[hit], '0, 1'b1);
      return;
    end
    if (seq[4:0] == 0) begin
      // Restart of a matching message: reopen with the new frame.
      start_message(hit, pgn, src, dst, pri, it.frame_data);
      return;
    end
    open_q[hit] = 1'b0;
    if (drop_cnt != 16'hFFFF) drop_cnt++;
    push_result(ST_DROP, pgn, src, dst, pri, '0, '0, 1'b1);
  endtask

  function automatic bit idle_now();
    return !quiet_run && ($urandom_range(99) < 34);
  endfunction

  // Send one input item and predict its results once it is transferred.
  // Valid stays high after the transfer until the next falling edge, where the
  // next call or the drain wait takes it over.
  task automatic send_item(logic op, logic [28:0] id, logic [63:0] d);
    in_item_t it;
    it.operation = op;
    it.can_id = id;
    it.frame_data = d;
    while (idle_now()) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_item(it);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Output side: random stalls, check every transfer against the oldest expectation.
  always @(negedge clk_i) begin
    if (rst_ni) out_ch.ready <= !idle_now();
  end

  always @(posedge clk_i) begin
    out_item_t exp_r;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_ch.payload);
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (exp_r !== out_ch.payload) begin
          $display("%0t: mismatch expected %p actual %p", $time, exp_r, out_ch.payload);
          fail_count++;
        end
      end
    end
  end

  function automatic logic [28:0] frame_id(logic [2:0] pri, logic [16:0] pgn, logic [7:0] src,
                                           logic [7:0] dst);
    logic [7:0] low;
    low = (pgn[15:8] < 8'd240) ? dst : pgn[7:0];
    return {pri, 1'b0, pgn[16], pgn[15:8], low, src};
  endfunction

  function automatic logic [16:0] random_fast_pgn();
    logic [16:0] list [6] = '{17'd65240, 17'd126208, 17'd129029, 17'd130824,
                              17'd126464, 17'd129540};
    return list[$urandom_range(5)];
  endfunction

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [15:0] val);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_ENTRY_MAX_AGE) age_limit = val;
    else sweep_every = val;
  endtask

  // Send one whole message: start frame then continuation frames.
  task automatic send_message(logic [2:0] pri, logic [16:0] pgn, logic [7:0] src,
                              logic [7:0] dst, logic [2:0] ctr, logic [7:0] len);
    logic [63:0] d;
    int frames;
    d = {$urandom, $urandom};
    d[7:0] = {ctr, 5'd0};
    d[15:8] = len;
    send_item(OP_FRAME, frame_id(pri, pgn, src, dst), d);
    frames = (len > 223) ? 32 : (int'(len) + 1 - 6 + 6) / 7;
    for (int f = 1; f <= frames && f < 32; f++) begin
      d = {$urandom, $urandom};
      d[7:0] = {ctr, f[4:0]};
      send_item(OP_FRAME, frame_id(pri, pgn, src, dst), d);
    end
  endtask

  task automatic test_directed();
    // Passthrough frames at the field extremes.
    send_item(OP_FRAME, '0, '0);
    send_item(OP_FRAME, 29'h1FFF_FFFF, '1);
    send_item(OP_FRAME, 29'h0AAA_5555, 64'h5555_AAAA_5555_AAAA);
    // Short message completing at once, zero length, and a long saturating one.
    send_message(3'd7, 17'd129029, 8'h12, 8'h34, 3'd0, 8'd5);
    send_message(3'd0, 17'd126208, 8'hFF, 8'h00, 3'd7, 8'd0);
    send_message(3'd2, 17'd130824, 8'h01, 8'hFF, 3'd1, 8'd255);
    // Orphan continuation.
    send_item(OP_FRAME, frame_id(3'd1, 17'd129029, 8'h22, 8'h33), 64'h0000_0000_0000_0043);
    // Restart and sequence drop on an open message.
    send_item(OP_FRAME, frame_id(3'd1, 17'd126208, 8'h05, 8'h06), 64'h1122_3344_5566_3020);
    send_item(OP_FRAME, frame_id(3'd1, 17'd126208, 8'h05, 8'h06), 64'h9988_7766_5544_2820);
    send_item(OP_FRAME, frame_id(3'd1, 17'd126208, 8'h05, 8'h06), 64'h0000_0000_0000_0023);
    // Fill every slot, then a ninth start finds the table full.
    for (int i = 0; i < 9; i++)
      send_item(OP_FRAME, frame_id(3'd3, 17'd129540, i[7:0], 8'h10), 64'h0000_0000_0000_5000);
    send_item(OP_TICK, '0, '0);
  endtask

  task automatic test_ageing();
    write_reg(REG_ENTRY_MAX_AGE, 16'd0);
    write_reg(REG_GC_INTERVAL, 16'd1);
    for (int i = 0; i < 3; i++) send_item(OP_TICK, 29'(i), '0);
    write_reg(REG_ENTRY_MAX_AGE, 16'd2);
    write_reg(REG_GC_INTERVAL, 16'd3);
    send_item(OP_FRAME, frame_id(3'd4, 17'd129029, 8'h77, 8'h88), 64'h0000_0000_0000_3200);
    for (int i = 0; i < 7; i++) send_item(OP_TICK, '1, '1);
    write_reg(REG_ENTRY_MAX_AGE, 16'hFFFF);
    write_reg(REG_GC_INTERVAL, 16'hFFFF);
    send_item(OP_TICK, '0, '0);
  endtask

  task automatic test_random(int count);
    int first;
    int r;
    logic [16:0] pgn;
    first = items_sent;
    while (items_sent - first < count) begin
      r = $urandom_range(99);
      if (r < 55) begin
        pgn = random_fast_pgn();
        send_message(3'($urandom), pgn, 8'($urandom_range(3)), 8'($urandom_range(2)),
                     3'($urandom), ($urandom_range(9) == 0) ? 8'($urandom)
                                                             : 8'($urandom_range(40)));
      end else if (r < 80) begin
        // Broken sequences, orphans and restarts among a few keys.
        pgn = random_fast_pgn();
        send_item(OP_FRAME, frame_id(3'($urandom), pgn, 8'($urandom_range(3)),
                  8'($urandom_range(2))), {$urandom, $urandom});
      end else if (r < 92) begin
        send_item(OP_FRAME, 29'($urandom), {$urandom, $urandom});
      end else begin
        send_item(OP_TICK, 29'($urandom), {$urandom, $urandom});
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    age_limit = 16'd100;
    sweep_every = 16'd10;
    sweep_cnt = '0;
    drop_cnt = '0;
    for (int s = 0; s < NumSlots; s++) open_q[s] = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_ageing();
    write_reg(REG_ENTRY_MAX_AGE, 16'd3);
    write_reg(REG_GC_INTERVAL, 16'd2);
    test_random(100);
    // A stretch with no idling on either side.
    quiet_run = 1'b1;
    test_random(60);
    quiet_run = 1'b0;
    write_reg(REG_ENTRY_MAX_AGE, 16'd100);
    write_reg(REG_GC_INTERVAL, 16'd10);
    test_random(107);
    wait_drained();
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #40ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
